// ----- rtl/core/shsa_pkg.sv -----
// shsa_pkg: shared types and constants of the salted handle slot allocator
// holds table geometry, operation and status codes and the controller states
// no dependencies
package shsa_pkg;

  localparam int unsigned SLOTS     = 256;
  localparam int unsigned SLOT_W    = $clog2(SLOTS);
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned ROW_IDX_W = $clog2(ROW_W);
  localparam int unsigned ROWS      = SLOTS / ROW_W;
  localparam int unsigned ROW_SEL_W = $clog2(ROWS);
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ST_W      = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_W     = 56;

  localparam logic [ID_W-1:0]     ID_FLOOR  = 16'h8000;
  localparam logic [HANDLE_W-1:0] NO_HANDLE = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_ZERO = 2'd1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 3'd0,
    OP_ALLOC_AT = 3'd1,
    OP_RELEASE  = 3'd2,
    OP_LOOKUP   = 3'd3,
    OP_CLEAR    = 3'd4
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    STS_OK    = 3'd0,
    STS_FULL  = 3'd1,
    STS_BUSY  = 3'd2,
    STS_STALE = 3'd3,
    STS_ZERO  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SHRINK,
    S_RESP
  } state_e;

endpackage

// ----- rtl/core/salted_handle_slot_allocator_unit.sv -----
// salted_handle_slot_allocator_unit: generational handle allocator over a slot table
// used bits in flip-flops, per-slot identifiers in a synchronous memory
// depends on shsa_pkg
//
// One operation at a time. The input item is taken when the block is idle, even
// while the previous result still waits on the output register. Each operation
// passes through accept (with the identifier memory read), execute and result
// load; the result load waits until the output register is free. Allocate adds
// a search of the 16-slot rows of the used-bit array from the free hint upward,
// up to the first free slot or the last row; with the hint at the end of the
// table there is no search. A release of the highest used slot adds a downward
// search, one 16-slot row at a time, for the new high-water mark. Clear resets
// all used bits at once, so there is no clearing pass. Configuration writes
// are taken in every cycle.
module salted_handle_slot_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [shsa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [shsa_pkg::ID_W-1:0]      cfg_data_i,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [shsa_pkg::HANDLE_W-1:0]  s_axis_tdata,  // handle_in[31:0]
  input  logic [shsa_pkg::OP_W-1:0]      s_axis_tuser,  // opcode[2:0]
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // handle_out[31:0], status[34:32], live_count[43:35], high_water[52:44], zero[55:53]
  output logic [shsa_pkg::OUT_W-1:0]     m_axis_tdata
);

  localparam int unsigned SW = shsa_pkg::SLOT_W;
  localparam int unsigned CW = shsa_pkg::CNT_W;
  localparam int unsigned IW = shsa_pkg::ID_W;
  localparam int unsigned HW = shsa_pkg::HANDLE_W;
  localparam int unsigned RW = shsa_pkg::ROW_W;
  localparam int unsigned RIW = shsa_pkg::ROW_IDX_W;
  localparam int unsigned RSW = shsa_pkg::ROW_SEL_W;
  localparam int unsigned PAD_W = shsa_pkg::OUT_W - HW - shsa_pkg::ST_W - 2 * CW;

  shsa_pkg::state_e  state_q, state_d;
  shsa_pkg::opcode_e op_q;
  logic [HW-1:0]     hdl_q;

  logic [IW-1:0]              seed_q, seed_d;
  logic                       rej_zero_q, rej_zero_d;
  logic [shsa_pkg::SLOTS-1:0] used_q, used_d;
  logic [IW-1:0]              ctr_q, ctr_d;
  logic [CW-1:0]              hint_q, hint_d;
  logic [CW-1:0]              total_q, total_d;
  logic [CW-1:0]              extent_q, extent_d;
  logic [RSW-1:0]             row_q, row_d;

  logic [HW-1:0]              res_handle_q, res_handle_d;
  shsa_pkg::status_e          res_status_q, res_status_d;

  logic                       m_valid_q, m_valid_d;
  logic [shsa_pkg::OUT_W-1:0] m_data_q, m_data_d;

  logic [IW-1:0] id_mem [shsa_pkg::SLOTS];
  logic [IW-1:0] mem_rdata_q;
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [IW-1:0] mem_wdata;

  logic in_accept;
  logic out_free;

  // decoded request
  logic [IW-1:0] hdl_id;
  logic [SW-1:0] hdl_slot;
  logic          hdl_hi_nz;
  logic [CW-1:0] hdl_slot_ext;
  logic          check_bad_zero;
  logic          check_stale;

  // identifier counter advance
  logic [IW-1:0] ctr_inc;
  logic [IW-1:0] ctr_take;

  // upward free search in one row
  logic [RW-1:0]  srch_row;
  logic [RW-1:0]  srch_masked;
  logic           srch_found;
  logic [RIW-1:0] srch_idx;
  logic [SW-1:0]  srch_slot;
  logic [CW-1:0]  srch_slot_ext;

  // downward used search in one row
  logic [CW-1:0]  ext_m1;
  logic [RSW-1:0] shr_row_sel;
  logic [RW-1:0]  shr_row;
  logic [RW-1:0]  shr_masked;
  logic           shr_found;
  logic [RIW-1:0] shr_idx;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == shsa_pkg::S_IDLE);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign hdl_id       = hdl_q[HW-1:IW];
  assign hdl_slot     = hdl_q[SW-1:0];
  assign hdl_hi_nz    = |hdl_q[IW-1:SW];
  assign hdl_slot_ext = CW'(hdl_slot);

  assign check_bad_zero = (hdl_id == '0) && rej_zero_q;
  assign check_stale    = hdl_hi_nz || (hdl_slot_ext >= extent_q) || !used_q[hdl_slot] ||
                          ((hdl_id != '0) && (hdl_id != mem_rdata_q));

  assign ctr_inc  = ctr_q + IW'(1);
  assign ctr_take = (ctr_inc == '0) ? shsa_pkg::ID_FLOOR : ctr_inc;

  // first free slot in the current row, slots below the hint count as taken
  always_comb begin
    srch_row = used_q[row_q*RW +: RW];
    for (int i = 0; i < RW; i++) begin
      srch_masked[i] = srch_row[i] ||
                       ((row_q == hint_q[SW-1:RIW]) && (RIW'(i) < hint_q[RIW-1:0]));
    end
    srch_found = 1'b0;
    srch_idx   = '0;
    for (int i = RW - 1; i >= 0; i--) begin
      if (!srch_masked[i]) begin
        srch_found = 1'b1;
        srch_idx   = RIW'(i);
      end
    end
  end

  assign srch_slot     = {row_q, srch_idx};
  assign srch_slot_ext = CW'(srch_slot);

  // highest used slot below the current extent, one row per cycle
  assign ext_m1      = extent_q - CW'(1);
  assign shr_row_sel = ext_m1[SW-1:RIW];

  always_comb begin
    shr_row = used_q[shr_row_sel*RW +: RW];
    for (int i = 0; i < RW; i++) begin
      shr_masked[i] = shr_row[i] && (RIW'(i) <= ext_m1[RIW-1:0]);
    end
    shr_found = 1'b0;
    shr_idx   = '0;
    for (int i = 0; i < RW; i++) begin
      if (shr_masked[i]) begin
        shr_found = 1'b1;
        shr_idx   = RIW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      shsa_pkg::S_IDLE: begin
        if (in_accept) state_d = shsa_pkg::S_EXEC;
      end
      shsa_pkg::S_EXEC: begin
        state_d = shsa_pkg::S_RESP;
        if (op_q == shsa_pkg::OP_ALLOC && !hint_q[SW]) begin
          state_d = shsa_pkg::S_SEARCH;
        end else if (op_q == shsa_pkg::OP_RELEASE && !check_bad_zero && !check_stale &&
                     (hdl_slot_ext + CW'(1) == extent_q)) begin
          state_d = shsa_pkg::S_SHRINK;
        end
      end
      shsa_pkg::S_SEARCH: begin
        if (srch_found || row_q == RSW'(shsa_pkg::ROWS - 1)) state_d = shsa_pkg::S_RESP;
      end
      shsa_pkg::S_SHRINK: begin
        if (extent_q == '0 || shr_found) state_d = shsa_pkg::S_RESP;
      end
      shsa_pkg::S_RESP: begin
        if (out_free) state_d = shsa_pkg::S_IDLE;
      end
      default: state_d = shsa_pkg::S_IDLE;
    endcase
  end

  // datapath and table updates
  always_comb begin
    seed_d       = seed_q;
    rej_zero_d   = rej_zero_q;
    used_d       = used_q;
    ctr_d        = ctr_q;
    hint_d       = hint_q;
    total_d      = total_q;
    extent_d     = extent_q;
    row_d        = row_q;
    res_handle_d = res_handle_q;
    res_status_d = res_status_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    mem_we       = 1'b0;
    mem_waddr    = hdl_slot;
    mem_wdata    = hdl_id;

    if (cfg_valid_i) begin
      if (cfg_index_i == shsa_pkg::CFG_SEED) seed_d = cfg_data_i;
      if (cfg_index_i == shsa_pkg::CFG_REJECT_ZERO) rej_zero_d = cfg_data_i[0];
    end

    unique case (state_q)
      shsa_pkg::S_EXEC: begin
        res_handle_d = shsa_pkg::NO_HANDLE;
        res_status_d = shsa_pkg::STS_OK;
        unique case (op_q)
          shsa_pkg::OP_ALLOC: begin
            row_d = hint_q[SW-1:RIW];
            if (hint_q[SW]) res_status_d = shsa_pkg::STS_FULL;
          end
          shsa_pkg::OP_ALLOC_AT: begin
            if (hdl_hi_nz) begin
              res_status_d = shsa_pkg::STS_BUSY;
            end else if (hdl_id == '0) begin
              res_status_d = shsa_pkg::STS_ZERO;
            end else if (used_q[hdl_slot]) begin
              res_status_d = shsa_pkg::STS_BUSY;
            end else begin
              mem_we           = 1'b1;
              used_d[hdl_slot] = 1'b1;
              ctr_d            = ctr_take;
              total_d          = total_q + CW'(1);
              if (hdl_slot_ext >= extent_q) extent_d = hdl_slot_ext + CW'(1);
              res_handle_d     = hdl_q;
            end
          end
          shsa_pkg::OP_RELEASE, shsa_pkg::OP_LOOKUP: begin
            if (check_bad_zero) begin
              res_status_d = shsa_pkg::STS_ZERO;
            end else if (check_stale) begin
              res_status_d = shsa_pkg::STS_STALE;
            end else begin
              res_handle_d = {mem_rdata_q, hdl_q[IW-1:0]};
              if (op_q == shsa_pkg::OP_RELEASE) begin
                used_d[hdl_slot] = 1'b0;
                total_d          = total_q - CW'(1);
                if (hdl_slot_ext < hint_q) hint_d = hdl_slot_ext;
                // top slot freed: drop the extent to it, then search below
                if (hdl_slot_ext + CW'(1) == extent_q) extent_d = hdl_slot_ext;
              end
            end
          end
          shsa_pkg::OP_CLEAR: begin
            used_d   = '0;
            total_d  = '0;
            extent_d = '0;
            hint_d   = '0;
            ctr_d    = seed_q | shsa_pkg::ID_FLOOR;
          end
          default: ;
        endcase
      end
      shsa_pkg::S_SEARCH: begin
        if (srch_found) begin
          mem_we            = 1'b1;
          mem_waddr         = srch_slot;
          mem_wdata         = ctr_q;
          used_d[srch_slot] = 1'b1;
          ctr_d             = ctr_take;
          total_d           = total_q + CW'(1);
          hint_d            = srch_slot_ext + CW'(1);
          if (srch_slot_ext >= extent_q) extent_d = srch_slot_ext + CW'(1);
          res_handle_d      = {ctr_q, IW'(srch_slot)};
        end else if (row_q == RSW'(shsa_pkg::ROWS - 1)) begin
          res_status_d = shsa_pkg::STS_FULL;
        end else begin
          row_d = row_q + RSW'(1);
        end
      end
      shsa_pkg::S_SHRINK: begin
        if (extent_q != '0) begin
          if (shr_found) begin
            extent_d = CW'({shr_row_sel, shr_idx}) + CW'(1);
          end else begin
            extent_d = CW'({shr_row_sel, RIW'(0)});
          end
        end
      end
      shsa_pkg::S_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {{PAD_W{1'b0}}, extent_q, total_q, res_status_q, res_handle_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= shsa_pkg::S_IDLE;
      seed_q     <= '0;
      rej_zero_q <= 1'b0;
      used_q     <= '0;
      ctr_q      <= shsa_pkg::ID_FLOOR;
      hint_q     <= '0;
      total_q    <= '0;
      extent_q   <= '0;
      row_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      seed_q     <= seed_d;
      rej_zero_q <= rej_zero_d;
      used_q     <= used_d;
      ctr_q      <= ctr_d;
      hint_q     <= hint_d;
      total_q    <= total_d;
      extent_q   <= extent_d;
      row_q      <= row_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= shsa_pkg::opcode_e'(s_axis_tuser);
      hdl_q <= s_axis_tdata;
    end
    res_handle_q <= res_handle_d;
    res_status_q <= res_status_d;
    m_data_q     <= m_data_d;
  end

  // identifier memory, read issued with the input transaction
  always_ff @(posedge clk_i) begin
    if (mem_we) id_mem[mem_waddr] <= mem_wdata;
    if (in_accept) mem_rdata_q <= id_mem[s_axis_tdata[SW-1:0]];
  end

endmodule

// ----- verif/salted_handle_slot_allocator_unit_test.sv -----
// salted_handle_slot_allocator_unit_test: self-checking bench for the slot allocator
// clocked driver and monitor processes around a shadow model of the slot table
// depends on shsa_pkg and salted_handle_slot_allocator_unit
module salted_handle_slot_allocator_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [shsa_pkg::OP_W-1:0]      OP_RSVD_FIRST = 3'd5;
  localparam logic [shsa_pkg::CFG_IDX_W-1:0] CFG_SPARE_A   = 2'd2;
  localparam logic [shsa_pkg::CFG_IDX_W-1:0] CFG_SPARE_B   = 2'd3;
  localparam int HOLD_LEN = 400;

  typedef enum int { MIX_FILL, MIX_EVEN, MIX_DRAIN } op_mix_e;

  typedef struct packed {
    logic [shsa_pkg::OP_W-1:0]     op;
    logic [shsa_pkg::HANDLE_W-1:0] handle;
  } slot_req_t;

  typedef struct packed {
    logic [shsa_pkg::HANDLE_W-1:0] handle;
    shsa_pkg::status_e             st;
    logic [shsa_pkg::CNT_W-1:0]    live;
    logic [shsa_pkg::CNT_W-1:0]    hw;
  } slot_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready_o;
  logic [shsa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [shsa_pkg::ID_W-1:0]      cfg_data  = '0;

  logic                          req_valid  = 1'b0;
  logic                          s_axis_tready;
  logic [shsa_pkg::HANDLE_W-1:0] req_handle = '0;
  logic [shsa_pkg::OP_W-1:0]     req_op     = '0;

  logic                       m_axis_tvalid;
  logic                       res_ready = 1'b0;
  logic [shsa_pkg::OUT_W-1:0] m_axis_tdata;

  salted_handle_slot_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (req_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (req_handle),
    .s_axis_tuser  (req_op),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (res_ready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the slot table
  bit          used_m [shsa_pkg::SLOTS];
  logic [15:0] salt_m [shsa_pkg::SLOTS];
  logic [15:0] salt_ctr_m = shsa_pkg::ID_FLOOR;
  int unsigned hint_m   = 0;
  int unsigned live_m   = 0;
  int unsigned extent_m = 0;
  logic [15:0] seed_m   = '0;
  bit          reject_zero_m = 1'b0;

  slot_req_t   req_q[$];
  slot_reply_t slot_reply_due_q[$];

  bit req_fire    = 1'b0;
  bit steady      = 1'b0;
  bit hold_armed  = 1'b0;
  int hold_cycles = 0;
  int mismatches  = 0;
  int cfg_writes  = 0;
  int replies_seen = 0;
  int st_seen [8];

  function automatic logic [15:0] next_salt();
    logic [15:0] id;
    id = salt_ctr_m;
    salt_ctr_m = salt_ctr_m + 16'd1;
    if (salt_ctr_m == 16'd0) salt_ctr_m = shsa_pkg::ID_FLOOR;
    return id;
  endfunction

  function automatic slot_reply_t predict_slot_reply(logic [shsa_pkg::OP_W-1:0] op,
                                                     logic [shsa_pkg::HANDLE_W-1:0] h);
    slot_reply_t r;
    int unsigned s;
    int unsigned sl;
    logic [15:0] id;
    r.handle = shsa_pkg::NO_HANDLE;
    r.st = shsa_pkg::STS_OK;
    id = h[31:16];
    sl = h[15:0];
    case (op)
      shsa_pkg::OP_ALLOC: begin
        s = hint_m;
        while (s < shsa_pkg::SLOTS && used_m[s]) s++;
        if (s >= shsa_pkg::SLOTS) begin
          r.st = shsa_pkg::STS_FULL;
        end else begin
          id = next_salt();
          used_m[s] = 1'b1;
          salt_m[s] = id;
          live_m++;
          hint_m = s + 1;
          if (s >= extent_m) extent_m = s + 1;
          r.handle = {id, 16'(s)};
        end
      end
      shsa_pkg::OP_ALLOC_AT: begin
        if (sl >= shsa_pkg::SLOTS) begin
          r.st = shsa_pkg::STS_BUSY;
        end else if (id == 16'd0) begin
          r.st = shsa_pkg::STS_ZERO;
        end else if (used_m[sl]) begin
          r.st = shsa_pkg::STS_BUSY;
        end else begin
          void'(next_salt());
          used_m[sl] = 1'b1;
          salt_m[sl] = id;
          live_m++;
          if (sl >= extent_m) extent_m = sl + 1;
          r.handle = h;
        end
      end
      shsa_pkg::OP_RELEASE, shsa_pkg::OP_LOOKUP: begin
        if (id == 16'd0 && reject_zero_m) r.st = shsa_pkg::STS_ZERO;
        else if (sl >= extent_m || sl >= shsa_pkg::SLOTS) r.st = shsa_pkg::STS_STALE;
        else if (!used_m[sl]) r.st = shsa_pkg::STS_STALE;
        else if (id != 16'd0 && id != salt_m[sl]) r.st = shsa_pkg::STS_STALE;
        if (r.st == shsa_pkg::STS_OK) begin
          r.handle = {salt_m[sl], 16'(sl)};
          if (op == shsa_pkg::OP_RELEASE) begin
            used_m[sl] = 1'b0;
            if (sl < hint_m) hint_m = sl;
            // pull the extent down past trailing free slots
            if (sl + 1 == extent_m) begin
              do extent_m--; while (extent_m > 0 && !used_m[extent_m-1]);
            end
            live_m--;
          end
        end
      end
      shsa_pkg::OP_CLEAR: begin
        used_m     = '{default: 1'b0};
        extent_m   = 0;
        live_m     = 0;
        hint_m     = 0;
        salt_ctr_m = seed_m | shsa_pkg::ID_FLOOR;
      end
      default: ;
    endcase
    r.live = 9'(live_m);
    r.hw   = 9'(extent_m);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // request driver
  always @(negedge clk_i) begin
    slot_req_t nxt;
    if (rst_ni) begin
      if (!req_valid || req_fire) begin
        if (req_q.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
          nxt = req_q.pop_front();
          req_valid  <= 1'b1;
          req_op     <= nxt.op;
          req_handle <= nxt.handle;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off counted here
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_armed && hold_cycles < HOLD_LEN) begin
        hold_cycles <= hold_cycles + 1;
        res_ready <= 1'b0;
      end else begin
        res_ready <= steady || ($urandom_range(99) >= 33);
      end
    end
  end

  // monitor: predict on request transactions, check on result transactions
  always @(posedge clk_i) begin
    slot_reply_t due;
    if (rst_ni) begin
      req_fire <= req_valid && s_axis_tready;
      if (req_valid && s_axis_tready)
        slot_reply_due_q.push_back(predict_slot_reply(req_op, req_handle));
      if (m_axis_tvalid && res_ready) begin
        if (slot_reply_due_q.size() == 0) begin
          $display("%0t ns: result with nothing expected, actual %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          due = slot_reply_due_q.pop_front();
          check_field("handle_out", due.handle, m_axis_tdata[31:0]);
          check_field("status", 32'(due.st), 32'(m_axis_tdata[34:32]));
          check_field("live_count", 32'(due.live), 32'(m_axis_tdata[43:35]));
          check_field("high_water", 32'(due.hw), 32'(m_axis_tdata[52:44]));
          check_field("pad", 32'd0, 32'(m_axis_tdata[55:53]));
          st_seen[int'(due.st)]++;
          replies_seen++;
        end
      end
    end
  end

  task automatic write_reg(logic [shsa_pkg::CFG_IDX_W-1:0] idx,
                           logic [shsa_pkg::ID_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == shsa_pkg::CFG_SEED) seed_m = data;
    else if (idx == shsa_pkg::CFG_REJECT_ZERO) reject_zero_m = data[0];
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_room();
    while (req_q.size() >= 2) @(negedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (req_q.size() != 0 || req_valid || slot_reply_due_q.size() != 0);
    // allow for any operation still inside the block
    repeat (20) @(negedge clk_i);
  endtask

  task automatic push_req(logic [shsa_pkg::OP_W-1:0] op, logic [shsa_pkg::HANDLE_W-1:0] h);
    wait_room();
    req_q.push_back(slot_req_t'{op: op, handle: h});
  endtask

  function automatic int live_slot_pick();
    int unsigned start;
    int unsigned s;
    if (live_m == 0 || extent_m == 0) return -1;
    start = $urandom_range(extent_m - 1);
    for (int unsigned k = 0; k < extent_m; k++) begin
      s = (start + k) % extent_m;
      if (used_m[s]) return int'(s);
    end
    return -1;
  endfunction

  // handle for release or lookup: mostly live, the rest stale or malformed
  function automatic logic [shsa_pkg::HANDLE_W-1:0] probe_handle();
    int r;
    int s;
    r = $urandom_range(99);
    s = live_slot_pick();
    if (r < 65 && s >= 0) return {(r < 8) ? 16'h0 : salt_m[s], 16'(s)};
    case ($urandom_range(3))
      0: return {16'($urandom_range(16'hFFFF, 1)), 16'($urandom_range(extent_m))};
      1: return {16'($urandom()), 16'($urandom_range(16'hFFFF, shsa_pkg::SLOTS))};
      2: return $urandom();
      default: return {16'h0, 16'($urandom_range(shsa_pkg::SLOTS - 1))};
    endcase
  endfunction

  function automatic logic [shsa_pkg::HANDLE_W-1:0] place_handle();
    int r;
    r = $urandom_range(99);
    if (r < 70) return {16'($urandom_range(16'hFFFF, 1)), 16'($urandom_range(shsa_pkg::SLOTS - 1))};
    if (r < 80) return {16'h0, 16'($urandom_range(shsa_pkg::SLOTS - 1))};
    if (r < 90) return {16'($urandom()), 16'($urandom_range(16'hFFFF, shsa_pkg::SLOTS))};
    return $urandom();
  endfunction

  function automatic logic [shsa_pkg::OP_W-1:0] draw_op(op_mix_e mix);
    int r;
    int lim [5];
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:  lim = '{78, 88, 92, 98, 98};
      MIX_EVEN:  lim = '{30, 42, 70, 96, 98};
      default:   lim = '{12, 18, 60, 95, 98};
    endcase
    if (r < lim[0]) return shsa_pkg::OP_ALLOC;
    if (r < lim[1]) return shsa_pkg::OP_ALLOC_AT;
    if (r < lim[2]) return shsa_pkg::OP_RELEASE;
    if (r < lim[3]) return shsa_pkg::OP_LOOKUP;
    if (r < lim[4]) return shsa_pkg::OP_CLEAR;
    return OP_RSVD_FIRST + 3'($urandom_range(2));
  endfunction

  task automatic run_phase(op_mix_e mix, int count);
    int n;
    logic [shsa_pkg::OP_W-1:0] op;
    logic [shsa_pkg::HANDLE_W-1:0] h;
    n = 0;
    while (n < count) begin
      wait_room();
      op = draw_op(mix);
      case (op)
        shsa_pkg::OP_ALLOC_AT:                     h = place_handle();
        shsa_pkg::OP_RELEASE, shsa_pkg::OP_LOOKUP: h = probe_handle();
        default:                                   h = $urandom();
      endcase
      req_q.push_back(slot_req_t'{op: op, handle: h});
      if (op <= shsa_pkg::OP_CLEAR) n++;
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(shsa_pkg::CFG_SEED, 16'h0000);
    write_reg(shsa_pkg::CFG_REJECT_ZERO, 16'h0000);

    // empty table probes, then basic grants, placement errors and lookups
    push_req(shsa_pkg::OP_LOOKUP, 32'h0000_0000);
    push_req(shsa_pkg::OP_RELEASE, 32'hFFFF_FFFF);
    push_req(shsa_pkg::OP_ALLOC, 32'h0000_0000);
    push_req(shsa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
    push_req(shsa_pkg::OP_ALLOC_AT, 32'h1234_0005);
    push_req(shsa_pkg::OP_ALLOC_AT, 32'h0000_0007);
    push_req(shsa_pkg::OP_ALLOC_AT, 32'h1111_0005);
    push_req(shsa_pkg::OP_ALLOC_AT, 32'h1111_0100);
    push_req(shsa_pkg::OP_ALLOC_AT, 32'hFFFF_FFFF);
    push_req(shsa_pkg::OP_ALLOC_AT, 32'hFFFF_00FF);
    push_req(shsa_pkg::OP_ALLOC, 32'h0);
    push_req(shsa_pkg::OP_LOOKUP, 32'h8000_0000);
    push_req(shsa_pkg::OP_LOOKUP, 32'h0000_0005);
    push_req(shsa_pkg::OP_LOOKUP, 32'h9999_0001);
    push_req(shsa_pkg::OP_LOOKUP, 32'h1234_0004);
    // top slot release shrinks the extent, lower release moves the hint
    push_req(shsa_pkg::OP_RELEASE, 32'hFFFF_00FF);
    push_req(shsa_pkg::OP_LOOKUP, 32'h1234_0005);
    push_req(shsa_pkg::OP_RELEASE, 32'h8001_0001);
    push_req(shsa_pkg::OP_ALLOC, 32'h0);
    for (int k = 0; k < 3; k++) push_req(OP_RSVD_FIRST + 3'(k), $urandom());
    push_req(shsa_pkg::OP_CLEAR, 32'h0);
    wait_idle();

    // identifier wrap and rejected zero identifiers
    write_reg(shsa_pkg::CFG_SEED, 16'hFFFE);
    write_reg(shsa_pkg::CFG_REJECT_ZERO, 16'h0001);
    push_req(shsa_pkg::OP_CLEAR, 32'h0);
    for (int k = 0; k < 3; k++) push_req(shsa_pkg::OP_ALLOC, 32'h0);
    push_req(shsa_pkg::OP_LOOKUP, 32'h0000_0000);
    push_req(shsa_pkg::OP_RELEASE, 32'h0000_0001);
    wait_idle();

    write_reg(shsa_pkg::CFG_SEED, 16'h0000);
    write_reg(shsa_pkg::CFG_REJECT_ZERO, 16'h0000);
    push_req(shsa_pkg::OP_CLEAR, 32'h0);
    run_phase(MIX_FILL, 300);
    wait_idle();

    write_reg(shsa_pkg::CFG_SEED, 16'hFFFF);
    write_reg(shsa_pkg::CFG_REJECT_ZERO, 16'h0001);
    hold_armed = 1'b1;
    run_phase(MIX_EVEN, 200);
    wait_idle();

    write_reg(shsa_pkg::CFG_SEED, 16'h7FFF);
    write_reg(shsa_pkg::CFG_REJECT_ZERO, 16'h0000);
    steady = 1'b1;
    run_phase(MIX_DRAIN, 200);
    wait_idle();
    steady = 1'b0;

    write_reg(shsa_pkg::CFG_SEED, 16'($urandom()));
    write_reg(shsa_pkg::CFG_REJECT_ZERO, 16'hFFFF);
    write_reg(CFG_SPARE_A, 16'($urandom()));
    write_reg(CFG_SPARE_B, 16'($urandom()));
    run_phase(MIX_EVEN, 200);
    wait_idle();

    write_reg(shsa_pkg::CFG_SEED, 16'($urandom()));
    write_reg(shsa_pkg::CFG_REJECT_ZERO, 16'($urandom()));
    push_req(shsa_pkg::OP_CLEAR, 32'h0);
    run_phase(MIX_FILL, 200);
    wait_idle();

    write_reg(shsa_pkg::CFG_SEED, 16'hFFF8);
    write_reg(shsa_pkg::CFG_REJECT_ZERO, 16'hFFFE);
    push_req(shsa_pkg::OP_CLEAR, 32'h0);
    run_phase(MIX_EVEN, 200);
    wait_idle();

    if (slot_reply_due_q.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, slot_reply_due_q.size());
      mismatches++;
    end
    $display("checked %0d results: ok %0d, full %0d, busy/range %0d, stale %0d, zero id %0d",
             replies_seen, st_seen[shsa_pkg::STS_OK], st_seen[shsa_pkg::STS_FULL],
             st_seen[shsa_pkg::STS_BUSY], st_seen[shsa_pkg::STS_STALE],
             st_seen[shsa_pkg::STS_ZERO]);
    $display("%0d register writes, %0d-cycle result hold-off, mismatches %0d",
             cfg_writes, HOLD_LEN, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout at %0t ns", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/shsa_pkg.sv
rtl/core/salted_handle_slot_allocator_unit.sv
verif/salted_handle_slot_allocator_unit_test.sv
